// ===== rtl/core/atl_pkg.sv =====
// shared constants, types and register codes for the antialiased line blend unit
package atl_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 4;

	// coordinate and product widths
	localparam int CW    = COORD_BITS + FRAC_BITS;
	localparam int PW    = CW + 2;
	localparam int DW    = CW + 1;
	localparam int PRODW = PW + DW;
	localparam int SQDW  = 2 * DW;
	localparam int LENW  = 2 * DW;
	localparam int DOTW  = PRODW + 1;

	// projection parameter t, Q0.16 plus the value one
	localparam int QBITS = 16;
	localparam int TW    = QBITS + 1;
	localparam int TDXW  = TW + 1 + DW;
	localparam int EW    = TDXW + 1;
	localparam int SHIFT = FRAC_BITS + 8;
	localparam int EMAG  = EW - 1 - SHIFT;

	// distance square root
	localparam int SQW   = 2 * EMAG;
	localparam int RADW  = SQW + 2;
	localparam int ROOTW = RADW / 2;
	localparam int REMW  = ROOTW + 3;
	localparam int COVW  = ROOTW + 2;

	localparam logic [FRAC_BITS-1:0] HALF_FRAC = FRAC_BITS'(1 << (FRAC_BITS - 1));

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COLOUR  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 3'd6;

	// register stages from input to output register
	localparam int PIPE_DEPTH = 3 + QBITS + 4 + ROOTW + 4;
	localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

	typedef struct packed {
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
		logic signed [CW-1:0] end_x;
		logic signed [CW-1:0] end_y;
		logic [11:0]          line_width;
		logic [23:0]          colour;
		logic [7:0]           alpha;
	} cfg_t;

	typedef struct packed {
		logic signed [PW-1:0] px;
		logic signed [PW-1:0] py;
		logic [23:0]          dest;
		logic                 t_zero;
		logic                 t_one;
	} div_side_t;

endpackage

// ===== rtl/core/atl_div.sv =====
// pipelined restoring divider for the projection parameter, one quotient bit per stage
module atl_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic [atl_pkg::LENW-1:0]           in_rem,
	input  logic [atl_pkg::LENW-1:0]           in_den,
	input  atl_pkg::div_side_t                 in_side,
	output logic                               out_valid,
	output logic [atl_pkg::QBITS-1:0]          out_quot,
	output atl_pkg::div_side_t                 out_side
);

	localparam int N = atl_pkg::QBITS;
	localparam int L = atl_pkg::LENW;

	logic [N-1:0]       v_s;
	logic [L-1:0]       rem_s  [N];
	logic [L-1:0]       den_s  [N];
	logic [N-1:0]       quot_s [N];
	atl_pkg::div_side_t side_s [N];

	logic [L-1:0]       rem_n  [N];
	logic [N-1:0]       quot_n [N];
	logic [L-1:0]       rem_p  [N];
	logic [L-1:0]       den_p  [N];
	logic [N-1:0]       quot_p [N];
	logic [L:0]         r2     [N];
	logic [L:0]         diff   [N];

	always_comb begin
		for (int k = 0; k < N; k++) begin
			rem_p[k]  = (k == 0) ? in_rem : rem_s[(k == 0) ? 0 : k - 1];
			den_p[k]  = (k == 0) ? in_den : den_s[(k == 0) ? 0 : k - 1];
			quot_p[k] = (k == 0) ? '0 : quot_s[(k == 0) ? 0 : k - 1];
			r2[k]     = {rem_p[k], 1'b0};
			diff[k]   = r2[k] - {1'b0, den_p[k]};
			if (r2[k] >= {1'b0, den_p[k]}) begin
				rem_n[k]  = diff[k][L-1:0];
				quot_n[k] = {quot_p[k][N-2:0], 1'b1};
			end else begin
				rem_n[k]  = r2[k][L-1:0];
				quot_n[k] = {quot_p[k][N-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[N-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				rem_s[k]  <= rem_n[k];
				den_s[k]  <= den_p[k];
				quot_s[k] <= quot_n[k];
				side_s[k] <= (k == 0) ? in_side : side_s[(k == 0) ? 0 : k - 1];
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign out_quot  = quot_s[N-1];
	assign out_side  = side_s[N-1];

endmodule

// ===== rtl/core/atl_sqrt.sv =====
// pipelined digit-by-digit integer square root, one root bit per stage
module atl_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [atl_pkg::RADW-1:0]     in_rad,
	input  logic [23:0]                  in_dest,
	output logic                         out_valid,
	output logic [atl_pkg::ROOTW-1:0]    out_root,
	output logic [23:0]                  out_dest
);

	localparam int N = atl_pkg::ROOTW;
	localparam int R = atl_pkg::RADW;
	localparam int M = atl_pkg::REMW;

	logic [N-1:0] v_s;
	logic [R-1:0] rad_s  [N];
	logic [M-1:0] rem_s  [N];
	logic [N-1:0] root_s [N];
	logic [23:0]  dest_s [N];

	logic [R-1:0] rad_p  [N];
	logic [M-1:0] rem_p  [N];
	logic [N-1:0] root_p [N];
	logic [M-1:0] cat    [N];
	logic [M-1:0] trial  [N];
	logic [M-1:0] rem_n  [N];
	logic [N-1:0] root_n [N];

	always_comb begin
		for (int k = 0; k < N; k++) begin
			rad_p[k]  = (k == 0) ? in_rad : rad_s[(k == 0) ? 0 : k - 1];
			rem_p[k]  = (k == 0) ? '0 : rem_s[(k == 0) ? 0 : k - 1];
			root_p[k] = (k == 0) ? '0 : root_s[(k == 0) ? 0 : k - 1];
			cat[k]    = {rem_p[k][M-3:0], rad_p[k][R-1 -: 2]};
			trial[k]  = M'({root_p[k], 2'b01});
			if (cat[k] >= trial[k]) begin
				rem_n[k]  = cat[k] - trial[k];
				root_n[k] = {root_p[k][N-2:0], 1'b1};
			end else begin
				rem_n[k]  = cat[k];
				root_n[k] = {root_p[k][N-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[N-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				rad_s[k]  <= {rad_p[k][R-3:0], 2'b00};
				rem_s[k]  <= rem_n[k];
				root_s[k] <= root_n[k];
				dest_s[k] <= (k == 0) ? in_dest : dest_s[(k == 0) ? 0 : k - 1];
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign out_root  = root_s[N-1];
	assign out_dest  = dest_s[N-1];

endmodule

// ===== rtl/core/atl_blend.sv =====
// coverage, effective alpha and per-channel blend, ending in the output register
module atl_blend (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  atl_pkg::cfg_t                cfg,
	input  logic                         in_valid,
	input  logic [atl_pkg::ROOTW-1:0]    in_dist,
	input  logic [23:0]                  in_dest,
	output logic                         out_valid,
	output logic [23:0]                  out_pixel,
	output logic                         out_touched
);

	localparam int CV = atl_pkg::COVW;

	logic              v_b1, v_b2, v_b3, v_q;
	logic [8:0]        cov_b1;
	logic              touch_b1, touch_b2, touch_b3;
	logic [23:0]       dest_b1, dest_b2, dest_b3;
	logic [7:0]        a_b2;
	logic signed [17:0] diff_b3 [3];
	logic              full_b3, zero_b3;

	logic signed [CV-1:0] cov;
	logic [16:0]          aprod;
	logic [23:0]          mix;
	logic signed [8:0]    cd   [3];
	logic [16:0]          mag  [3];
	logic [16:0]          quo  [3];
	logic [7:0]           dch  [3];

	// coverage in Q.8: half width plus half a pixel minus distance
	assign cov = $signed(CV'({cfg.line_width, 3'b000})) + $signed(CV'(128))
		- $signed(CV'(in_dist));
	assign aprod = 17'(cov_b1) * 17'(cfg.alpha);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			cd[c]  = $signed({1'b0, cfg.colour[8*c +: 8]}) - $signed({1'b0, dest_b2[8*c +: 8]});
			dch[c] = dest_b3[8*c +: 8];
			mag[c] = diff_b3[c][17] ? 17'(-diff_b3[c]) : 17'(diff_b3[c]);
			// exact floor of mag/255 for mag below 65535
			quo[c] = 17'(mag[c] + (mag[c] >> 8) + 17'd1) >> 8;
			mix[8*c +: 8] = diff_b3[c][17] ? dch[c] - quo[c][7:0] : dch[c] + quo[c][7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
			v_q  <= 1'b0;
		end else if (en) begin
			v_b1 <= in_valid;
			v_b2 <= v_b1;
			v_b3 <= v_b2;
			v_q  <= v_b3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			touch_b1 <= cov > 0;
			if (cov <= 0)
				cov_b1 <= 9'd0;
			else if (cov > $signed(CV'(256)))
				cov_b1 <= 9'd256;
			else
				cov_b1 <= cov[8:0];
			dest_b1 <= in_dest;

			a_b2     <= aprod[15:8];
			touch_b2 <= touch_b1;
			dest_b2  <= dest_b1;

			for (int c = 0; c < 3; c++)
				diff_b3[c] <= 18'(cd[c]) * 18'($signed({1'b0, a_b2}));
			full_b3  <= a_b2 == 8'd255;
			zero_b3  <= a_b2 == 8'd0;
			touch_b3 <= touch_b2;
			dest_b3  <= dest_b2;

			out_touched <= touch_b3;
			if (!touch_b3 || zero_b3)
				out_pixel <= dest_b3;
			else if (full_b3)
				out_pixel <= cfg.colour;
			else
				out_pixel <= mix;
		end
	end

	assign out_valid = v_q;

endmodule

// ===== rtl/core/antialiased_thick_line_blend_unit.sv =====
// top level of the antialiased thick line blend unit
// Shades one pixel per clock while the output is not stalled, against a capsule-shaped
// stroke: the pixel centre is projected onto the segment, the distance gives coverage
// and the stroke colour is blended over dest_pixel. The pipeline is 51 register stages
// deep (16 for the projection divider, 24 for the distance square root); it accepts a
// new pixel in every cycle that the output is not stalled, so throughput is one pixel
// per clock. Registers may only be written while no pixel is in flight.
module antialiased_thick_line_blend_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // pixel_x[11:0], pixel_y[23:12], dest_pixel[47:24]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // new_pixel[23:0]
	output logic        m_axis_tuser,   // touched[0]
	input  logic        cfg_we,
	input  logic [atl_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [atl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int CB = atl_pkg::COORD_BITS;
	localparam int PW = atl_pkg::PW;
	localparam int DW = atl_pkg::DW;

	atl_pkg::cfg_t cfg_q;
	logic          en;

	logic signed [DW-1:0] dx, dy;

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [PW-1:0] px_s1, py_s1, px_s2, py_s2, px_s3, py_s3;
	logic signed [PW-1:0] px_s4, py_s4;
	logic [23:0]          dest_s1, dest_s2, dest_s3, dest_s4, dest_s5, dest_s6, dest_s7;
	logic signed [atl_pkg::PRODW-1:0] pxdx_s2, pydy_s2;
	logic signed [atl_pkg::SQDW-1:0]  dxdx_s2, dydy_s2;
	logic [atl_pkg::LENW-1:0]         rem_s3, len2_s3;
	logic                             tz_s3, to_s3;
	logic signed [atl_pkg::TDXW-1:0]  tdx_s4, tdy_s4;
	logic [atl_pkg::EMAG-1:0]         ex_s5, ey_s5;
	logic [atl_pkg::SQW-1:0]          exx_s6, eyy_s6;
	logic [atl_pkg::RADW-1:0]         rad_s7;

	logic signed [atl_pkg::DOTW-1:0]  dot;
	logic [atl_pkg::LENW-1:0]         len2;
	logic                             tz;
	atl_pkg::div_side_t               side_in, side_out;
	logic                             div_valid;
	logic [atl_pkg::QBITS-1:0]        quot;
	logic [atl_pkg::TW-1:0]           t;
	logic signed [atl_pkg::EW-1:0]    ex, ey;
	logic [atl_pkg::EW-1:0]           exm, eym;
	logic                             sq_valid;
	logic [atl_pkg::ROOTW-1:0]        root_dist;
	logic [23:0]                      sq_dest;

	// whole pipeline advances unless a result is stuck at the output
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_x    <= '0;
			cfg_q.start_y    <= '0;
			cfg_q.end_x      <= '0;
			cfg_q.end_y      <= '0;
			cfg_q.line_width <= 12'd16;
			cfg_q.colour     <= 24'd0;
			cfg_q.alpha      <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_addr)
				atl_pkg::REG_START_X: cfg_q.start_x    <= cfg_wdata[atl_pkg::CW-1:0];
				atl_pkg::REG_START_Y: cfg_q.start_y    <= cfg_wdata[atl_pkg::CW-1:0];
				atl_pkg::REG_END_X:   cfg_q.end_x      <= cfg_wdata[atl_pkg::CW-1:0];
				atl_pkg::REG_END_Y:   cfg_q.end_y      <= cfg_wdata[atl_pkg::CW-1:0];
				atl_pkg::REG_WIDTH:   cfg_q.line_width <= cfg_wdata[11:0];
				atl_pkg::REG_COLOUR:  cfg_q.colour     <= cfg_wdata[23:0];
				atl_pkg::REG_ALPHA:   cfg_q.alpha      <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign dx = DW'(cfg_q.end_x) - DW'(cfg_q.start_x);
	assign dy = DW'(cfg_q.end_y) - DW'(cfg_q.start_y);

	assign dot  = atl_pkg::DOTW'(pxdx_s2) + atl_pkg::DOTW'(pydy_s2);
	assign len2 = atl_pkg::LENW'(dxdx_s2 + dydy_s2);
	assign tz   = (len2 == '0) || (dot <= 0);

	assign side_in.px     = px_s3;
	assign side_in.py     = py_s3;
	assign side_in.dest   = dest_s3;
	assign side_in.t_zero = tz_s3;
	assign side_in.t_one  = to_s3;

	always_comb begin
		if (side_out.t_one)
			t = atl_pkg::TW'(1) << atl_pkg::QBITS;
		else if (side_out.t_zero)
			t = '0;
		else
			t = {1'b0, quot};
	end

	// error vector in Q.20 then magnitude truncated to Q.8
	assign ex  = {{2{px_s4[PW-1]}}, px_s4, {atl_pkg::QBITS{1'b0}}} - atl_pkg::EW'(tdx_s4);
	assign ey  = {{2{py_s4[PW-1]}}, py_s4, {atl_pkg::QBITS{1'b0}}} - atl_pkg::EW'(tdy_s4);
	assign exm = ex[atl_pkg::EW-1] ? atl_pkg::EW'(-ex) : atl_pkg::EW'(ex);
	assign eym = ey[atl_pkg::EW-1] ? atl_pkg::EW'(-ey) : atl_pkg::EW'(ey);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= div_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// pixel centre relative to segment start
			px_s1   <= $signed({2'b00, s_axis_tdata[CB-1:0], atl_pkg::HALF_FRAC})
				- PW'(cfg_q.start_x);
			py_s1   <= $signed({2'b00, s_axis_tdata[2*CB-1:CB], atl_pkg::HALF_FRAC})
				- PW'(cfg_q.start_y);
			dest_s1 <= s_axis_tdata[2*CB +: 24];

			pxdx_s2 <= atl_pkg::PRODW'(px_s1) * atl_pkg::PRODW'(dx);
			pydy_s2 <= atl_pkg::PRODW'(py_s1) * atl_pkg::PRODW'(dy);
			dxdx_s2 <= atl_pkg::SQDW'(dx) * atl_pkg::SQDW'(dx);
			dydy_s2 <= atl_pkg::SQDW'(dy) * atl_pkg::SQDW'(dy);
			px_s2   <= px_s1;
			py_s2   <= py_s1;
			dest_s2 <= dest_s1;

			tz_s3   <= tz;
			to_s3   <= !tz && (dot >= $signed({2'b00, len2}));
			rem_s3  <= (tz || dot >= $signed({2'b00, len2})) ? '0 : dot[atl_pkg::LENW-1:0];
			len2_s3 <= len2;
			px_s3   <= px_s2;
			py_s3   <= py_s2;
			dest_s3 <= dest_s2;

			tdx_s4  <= atl_pkg::TDXW'($signed({1'b0, t})) * atl_pkg::TDXW'(dx);
			tdy_s4  <= atl_pkg::TDXW'($signed({1'b0, t})) * atl_pkg::TDXW'(dy);
			px_s4   <= side_out.px;
			py_s4   <= side_out.py;
			dest_s4 <= side_out.dest;

			ex_s5   <= exm[atl_pkg::SHIFT +: atl_pkg::EMAG];
			ey_s5   <= eym[atl_pkg::SHIFT +: atl_pkg::EMAG];
			dest_s5 <= dest_s4;

			exx_s6  <= atl_pkg::SQW'(ex_s5) * atl_pkg::SQW'(ex_s5);
			eyy_s6  <= atl_pkg::SQW'(ey_s5) * atl_pkg::SQW'(ey_s5);
			dest_s6 <= dest_s5;

			rad_s7  <= atl_pkg::RADW'(exx_s6) + atl_pkg::RADW'(eyy_s6);
			dest_s7 <= dest_s6;
		end
	end

	atl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.in_rem   (rem_s3),
		.in_den   (len2_s3),
		.in_side  (side_in),
		.out_valid(div_valid),
		.out_quot (quot),
		.out_side (side_out)
	);

	atl_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s7),
		.in_rad   (rad_s7),
		.in_dest  (dest_s7),
		.out_valid(sq_valid),
		.out_root (root_dist),
		.out_dest (sq_dest)
	);

	atl_blend u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.cfg        (cfg_q),
		.in_valid   (sq_valid),
		.in_dist    (root_dist),
		.in_dest    (sq_dest),
		.out_valid  (m_axis_tvalid),
		.out_pixel  (m_axis_tdata),
		.out_touched(m_axis_tuser)
	);

endmodule

// ===== rtl/core/atl_checker.sv =====
// port-level checker for the antialiased thick line blend unit, with its bind
module atl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [47:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        cfg_we,
	input logic [atl_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input logic [atl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic [atl_pkg::CNT_W-1:0] inflight_q;
	logic                      in_acc, out_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else if (in_acc && !out_acc)
			inflight_q <= inflight_q + 1'b1;
		else if (out_acc && !in_acc)
			inflight_q <= inflight_q - 1'b1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("output changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> inflight_q != '0)
		else $error("result without an accepted transaction");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= atl_pkg::CNT_W'(atl_pkg::PIPE_DEPTH))
		else $error("more transactions in flight than pipeline stages");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output side is ready");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> inflight_q == '0)
		else $error("configuration write while busy");

endmodule

bind antialiased_thick_line_blend_unit atl_checker u_atl_checker (.*);
